// File: sv/range_encoder_64bit_macros.svh
// ----------------------------------------------------------------------------
// range_encoder_64bit_macros.svh
// Assertion shorthands for the range encoder RTL.
// ----------------------------------------------------------------------------
`ifndef RANGE_ENCODER_64BIT_MACROS_SVH
`define RANGE_ENCODER_64BIT_MACROS_SVH

// same-cycle implication, clocked on clk_i, off while rst_ni is low
`define RE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/rngenc_pkg.sv
// ----------------------------------------------------------------------------
// rngenc_pkg
// Shared types and constants of the 64-bit range encoder.
// ----------------------------------------------------------------------------
package rngenc_pkg;

  localparam int FREQ_BITS       = 32;
  localparam int IN_QUEUE_DEPTH  = 2;
  localparam int OUT_QUEUE_DEPTH = 4;

  localparam logic [63:0] TOP_LIMIT = 64'h0100_0000_0000_0000;
  localparam logic [63:0] THRESHOLD = 64'hFF00_0000_0000_0000;
  localparam int          TOP_SHIFT = 24 + 32;
  localparam logic [7:0]  BYTE_MASK = 8'hFF;

  // dividend of the scaling step: (cum or cum+freq) * (range + 1) < 2^97
  localparam int A_BITS   = 33;
  localparam int DVD_BITS = 98;

  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  typedef struct packed {
    logic              is_flush;
    logic [A_BITS-1:0] a0;      // cum_freq
    logic [A_BITS-1:0] a1;      // cum_freq + sym_freq
    logic [31:0]       total;
  } item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [31:0] repeat_count;
    logic        last;
  } res_t;

endpackage

// File: sv/rngenc_fifo.sv
// ----------------------------------------------------------------------------
// rngenc_fifo
// Small register queue with full/empty flags.
// ----------------------------------------------------------------------------
module rngenc_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntBits = $clog2(Depth + 1);

  logic [Width-1:0]   mem_q [Depth];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CntBits'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(Depth - 1)) ? '0 : wr_ptr_q + PtrBits'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(Depth - 1)) ? '0 : rd_ptr_q + PtrBits'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntBits'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: sv/rngenc_front.sv
// ----------------------------------------------------------------------------
// rngenc_front
// Accepts input items, masks frequencies, forms the scaling operands and
// queues the classified item for the back end.
// ----------------------------------------------------------------------------
module rngenc_front #(
  parameter int FreqBits   = rngenc_pkg::FREQ_BITS,
  parameter int QueueDepth = rngenc_pkg::IN_QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic                opcode_i,
  input  logic [31:0]         cum_freq_i,
  input  logic [31:0]         sym_freq_i,
  input  logic [31:0]         total_freq_i,
  output rngenc_pkg::item_t   item_o,
  output logic                item_valid_o,
  input  logic                item_pop_i
);

  localparam int          MaskBits = (FreqBits > 32) ? 32 : FreqBits;
  localparam logic [31:0] FreqMask = 32'((64'd1 << MaskBits) - 64'd1);

  rngenc_pkg::item_t item_in;
  logic [31:0]       cum_m, freq_m;
  logic              q_empty;

  assign cum_m  = cum_freq_i & FreqMask;
  assign freq_m = sym_freq_i & FreqMask;

  always_comb begin
    item_in.is_flush = (opcode_i == rngenc_pkg::OP_FLUSH);
    item_in.a0       = {1'b0, cum_m};
    item_in.a1       = {1'b0, cum_m} + {1'b0, freq_m};
    item_in.total    = total_freq_i & FreqMask;
  end

  rngenc_fifo #(
    .Width ($bits(rngenc_pkg::item_t)),
    .Depth (QueueDepth)
  ) u_in_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (item_in),
    .full_o  (full),
    .pop_i   (item_pop_i),
    .data_o  (item_o),
    .empty_o (q_empty)
  );

  assign item_valid_o = !q_empty;

endmodule

// File: sv/rngenc_div.sv
// ----------------------------------------------------------------------------
// rngenc_div
// Restoring divider, 98-bit dividend by 32-bit divisor, two quotient bits
// per cycle. Keeps the low 64 quotient bits; a zero divisor gives all ones.
// ----------------------------------------------------------------------------
module rngenc_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [rngenc_pkg::DVD_BITS-1:0]   dividend_i,
  input  logic [31:0]                       divisor_i,
  output logic                              done_o,
  output logic [63:0]                       quot_o
);

  localparam int Steps   = rngenc_pkg::DVD_BITS / 2;
  localparam int CntBits = $clog2(Steps);

  logic                            busy_q, done_q;
  logic [CntBits-1:0]              cnt_q;
  logic [rngenc_pkg::DVD_BITS-1:0] dvd_q;
  logic [31:0]                     rem_q, rem1, rem2;
  logic [63:0]                     quot_q;
  logic [32:0]                     r1, r2;
  logic                            q1, q2;

  // remainder stays below the divisor, so 33 bits hold each trial value
  always_comb begin
    r1   = {rem_q, dvd_q[rngenc_pkg::DVD_BITS-1]};
    q1   = (r1 >= {1'b0, divisor_i});
    rem1 = q1 ? 32'(r1 - {1'b0, divisor_i}) : r1[31:0];
    r2   = {rem1, dvd_q[rngenc_pkg::DVD_BITS-2]};
    q2   = (r2 >= {1'b0, divisor_i});
    rem2 = q2 ? 32'(r2 - {1'b0, divisor_i}) : r2[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      dvd_q  <= '0;
      rem_q  <= '0;
      quot_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntBits'(Steps - 1);
        dvd_q  <= dividend_i;
        rem_q  <= '0;
        quot_q <= '0;
      end else if (busy_q) begin
        dvd_q  <= {dvd_q[rngenc_pkg::DVD_BITS-3:0], 2'b00};
        rem_q  <= rem2;
        quot_q <= {quot_q[61:0], q1, q2};
        cnt_q  <= cnt_q - CntBits'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = (divisor_i == '0) ? '1 : quot_q;

endmodule

// File: sv/rngenc_back.sv
// ----------------------------------------------------------------------------
// rngenc_back
// Coder state and sequencer: scaling multiply, two dividers, interval
// update, bytewise renormalization with cache and pending run, and flush.
// ----------------------------------------------------------------------------
`include "range_encoder_64bit_macros.svh"

module rngenc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rngenc_pkg::item_t   item_i,
  input  logic                item_valid_i,
  output logic                item_pop_o,
  output rngenc_pkg::res_t    res_o,
  output logic                res_push_o,
  input  logic                res_full_i
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_DIV_START, ST_DIV_WAIT, ST_UPDATE, ST_RENORM,
    ST_CACHE, ST_RUN, ST_FLUSH_SCAN, ST_FLUSH_CACHE, ST_FLUSH_RUN,
    ST_FLUSH_TAIL, ST_DONE
  } state_e;

  localparam int DB = rngenc_pkg::DVD_BITS;

  state_e            state_q;
  rngenc_pkg::item_t item_q;
  logic [63:0]       low_q, range_q, tail_q;
  logic              carry_q, cache_v_q;
  logic [31:0]       pend_q;
  logic [7:0]        cache_q;
  logic [DB-1:0]     acc0_q, acc1_q, acc_term;
  logic [63:0]       pp_q, mul_p;
  logic [31:0]       mul_a, mul_b;
  logic [2:0]        mcnt_q, pidx;
  logic [3:0]        k_q, n_q, tcnt_q;
  logic              hold_v_q;
  logic [7:0]        hold_byte_q;
  logic [31:0]       hold_cnt_q;

  logic [1:0]        div_done;
  logic [63:0]       quot0, quot1;
  logic [64:0]       lsum, bound;
  logic [8:0]        cache_sum;
  logic              sh_cond, emit_req, emit_ok, advance;
  logic [7:0]        emit_byte, run_byte;
  logic [31:0]       emit_cnt;
  logic [63:0]       scan_tail, scan_mask, scan_t;
  logic [3:0]        scan_cnt;

  // scaling multiply: one 32x32 product a cycle, registered and accumulated in the next cycle
  assign mul_a    = mcnt_q[1] ? item_q.a1[31:0] : item_q.a0[31:0];
  assign mul_b    = mcnt_q[0] ? range_q[63:32] : range_q[31:0];
  assign mul_p    = mul_a * mul_b;
  assign pidx     = mcnt_q - 3'd1;
  assign acc_term = pidx[0] ? {2'b00, pp_q, 32'h0} : {34'h0, pp_q};

  rngenc_div u_div0 (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (state_q == ST_DIV_START),
    .dividend_i (acc0_q), .divisor_i (item_q.total),
    .done_o (div_done[0]), .quot_o (quot0)
  );

  rngenc_div u_div1 (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (state_q == ST_DIV_START),
    .dividend_i (acc1_q), .divisor_i (item_q.total),
    .done_o (div_done[1]), .quot_o (quot1)
  );

  assign lsum      = {1'b0, low_q} + {1'b0, quot0};
  assign cache_sum = {1'b0, cache_q} + {8'h00, carry_q};
  assign sh_cond   = (low_q < rngenc_pkg::THRESHOLD) || carry_q;
  assign run_byte  = carry_q ? 8'h00 : rngenc_pkg::BYTE_MASK;
  assign bound     = {1'b0, low_q} + {1'b0, range_q} + 65'd1;

  // flush tail search: low bytes set to 0xFF while still inside the interval
  always_comb begin
    scan_tail = low_q;
    scan_cnt  = '0;
    for (int i = 0; i < 8; i++) begin
      scan_mask = {64{1'b1}} >> (56 - 8 * i);
      scan_t    = low_q | scan_mask;
      if (bound[64] || (scan_t < bound[63:0])) begin
        scan_tail = scan_t;
        scan_cnt  = scan_cnt + 4'd1;
      end
    end
  end

  always_comb begin
    emit_req  = 1'b0;
    emit_byte = cache_sum[7:0];
    emit_cnt  = 32'd1;
    unique case (state_q)
      ST_CACHE:       emit_req = cache_v_q;
      ST_RUN: begin
        emit_req  = (pend_q != '0);
        emit_byte = run_byte;
        emit_cnt  = pend_q;
      end
      ST_FLUSH_CACHE: emit_req = cache_v_q && ((n_q != '0) || (cache_sum != 9'h0FF));
      ST_FLUSH_RUN: begin
        emit_req  = !((n_q == '0) && !carry_q) && (pend_q != '0);
        emit_byte = run_byte;
        emit_cnt  = pend_q;
      end
      ST_FLUSH_TAIL: begin
        emit_req  = (tcnt_q < n_q);
        emit_byte = tail_q[63:rngenc_pkg::TOP_SHIFT];
      end
      default:        emit_req = 1'b0;
    endcase
  end

  // one result is held back so the final one of an item can carry last
  assign emit_ok    = !hold_v_q || !res_full_i;
  assign advance    = !emit_req || emit_ok;
  assign res_push_o = hold_v_q && !res_full_i && ((emit_req && emit_ok) || (state_q == ST_DONE));
  assign res_o      = '{out_byte: hold_byte_q, repeat_count: hold_cnt_q,
                        last: (state_q == ST_DONE)};
  assign item_pop_o = (state_q == ST_IDLE) && item_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      item_q      <= '0;
      low_q       <= '0;
      carry_q     <= 1'b0;
      range_q     <= '1;
      pend_q      <= '0;
      cache_q     <= '0;
      cache_v_q   <= 1'b0;
      acc0_q      <= '0;
      acc1_q      <= '0;
      pp_q        <= '0;
      mcnt_q      <= '0;
      k_q         <= '0;
      n_q         <= '0;
      tcnt_q      <= '0;
      tail_q      <= '0;
      hold_v_q    <= 1'b0;
      hold_byte_q <= '0;
      hold_cnt_q  <= '0;
    end else begin
      if (emit_req && emit_ok) begin
        hold_v_q    <= 1'b1;
        hold_byte_q <= emit_byte;
        hold_cnt_q  <= emit_cnt;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (item_valid_i) begin
            item_q <= item_i;
            mcnt_q <= '0;
            acc0_q <= DB'(item_i.a0) + (item_i.a0[32] ? {2'b00, range_q, 32'h0} : '0);
            acc1_q <= DB'(item_i.a1) + (item_i.a1[32] ? {2'b00, range_q, 32'h0} : '0);
            state_q <= item_i.is_flush ? ST_FLUSH_SCAN : ST_MUL;
          end
        end
        ST_MUL: begin
          pp_q   <= mul_p;
          mcnt_q <= mcnt_q + 3'd1;
          if (mcnt_q != '0) begin
            if (pidx[1]) acc1_q <= acc1_q + acc_term;
            else         acc0_q <= acc0_q + acc_term;
          end
          if (mcnt_q == 3'd4) state_q <= ST_DIV_START;
        end
        ST_DIV_START: state_q <= ST_DIV_WAIT;
        ST_DIV_WAIT: begin
          if (&div_done) state_q <= ST_UPDATE;
        end
        ST_UPDATE: begin
          low_q   <= lsum[63:0];
          if (lsum[64]) carry_q <= 1'b1;
          range_q <= quot1 - 64'd1 - quot0;
          k_q     <= '0;
          state_q <= ST_RENORM;
        end
        ST_RENORM: begin
          if ((k_q == 4'd8) || (range_q >= rngenc_pkg::TOP_LIMIT)) begin
            state_q <= ST_DONE;
          end else begin
            range_q <= {range_q[55:0], rngenc_pkg::BYTE_MASK};
            if (sh_cond) begin
              state_q <= ST_CACHE;
            end else begin
              if (pend_q != '1) pend_q <= pend_q + 32'd1;
              low_q <= {low_q[55:0], 8'h00};
              k_q   <= k_q + 4'd1;
            end
          end
        end
        ST_CACHE: begin
          if (advance) state_q <= ST_RUN;
        end
        ST_RUN: begin
          if (advance) begin
            pend_q    <= '0;
            cache_q   <= low_q[63:rngenc_pkg::TOP_SHIFT];
            cache_v_q <= 1'b1;
            carry_q   <= 1'b0;
            low_q     <= {low_q[55:0], 8'h00};
            k_q       <= k_q + 4'd1;
            state_q   <= ST_RENORM;
          end
        end
        ST_FLUSH_SCAN: begin
          n_q     <= 4'd8 - scan_cnt;
          tail_q  <= scan_tail;
          tcnt_q  <= '0;
          state_q <= ST_FLUSH_CACHE;
        end
        ST_FLUSH_CACHE: begin
          if (advance) state_q <= ST_FLUSH_RUN;
        end
        ST_FLUSH_RUN: begin
          if (advance) state_q <= ST_FLUSH_TAIL;
        end
        ST_FLUSH_TAIL: begin
          if (emit_req) begin
            if (emit_ok) begin
              tail_q <= {tail_q[55:0], 8'h00};
              tcnt_q <= tcnt_q + 4'd1;
            end
          end else begin
            low_q     <= '0;
            carry_q   <= 1'b0;
            range_q   <= '1;
            pend_q    <= '0;
            cache_q   <= '0;
            cache_v_q <= 1'b0;
            state_q   <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!hold_v_q || !res_full_i) begin
            hold_v_q <= 1'b0;
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `RE_ASSERT_IMP(a_push_has_room, res_push_o, !res_full_i, "result pushed into full queue")
  `RE_ASSERT_IMP(a_div_in_wait, div_done[0], state_q == ST_DIV_WAIT, "divider done outside wait")
  `RE_ASSERT_IMP(a_renorm_exit, state_q == ST_DONE, (range_q >= rngenc_pkg::TOP_LIMIT) || (k_q == 4'd8), "early end")
  `RE_ASSERT_NEXT(a_hold_drained, (state_q == ST_DONE) && !res_full_i, !hold_v_q, "held result not drained")

endmodule

// File: sv/range_encoder_64bit.sv
// ----------------------------------------------------------------------------
// range_encoder_64bit
// Encoding side of a 64-bit range coder with carry handling and byte runs.
// ----------------------------------------------------------------------------
// Both sides look like a queue: write an item with push while full is low,
// take results with pop while empty is low. An encode item (opcode 0) scales
// the interval by (range+1)/total_freq with two exact 98-bit divisions and
// renormalizes bytewise; a flush item (opcode 1) writes the shortest tail and
// returns the coder to its reset state. Each result is one byte value with a
// repeat count (runs of pending 0xFF, or 0x00 after a carry, come out as one
// result); last marks the final result of an item, and an item may give none.
// Sequence: an encode item runs the scaling multiply, then the two dividers
// side by side at two quotient bits per cycle over a 98-bit dividend, which
// set most of its time, then the update and one renormalize step per byte
// shift, via the cache and run states when a byte leaves the cache. A flush
// scans for the tail, then emits the cache, run and tail bytes. A result on a
// stalled output holds the back end only; the input queue keeps taking items while not full.
// ----------------------------------------------------------------------------
module range_encoder_64bit #(
  parameter int FreqBits      = rngenc_pkg::FREQ_BITS,
  parameter int InQueueDepth  = rngenc_pkg::IN_QUEUE_DEPTH,
  parameter int OutQueueDepth = rngenc_pkg::OUT_QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input queue side
  input  logic        push,
  output logic        full,
  input  logic        opcode_i,
  input  logic [31:0] cum_freq_i,
  input  logic [31:0] sym_freq_i,
  input  logic [31:0] total_freq_i,
  // result queue side
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic [31:0] repeat_count_o,
  output logic        last_o
);

  rngenc_pkg::item_t item;
  logic              item_valid, item_pop;
  rngenc_pkg::res_t  res_in, res_out;
  logic              res_push, res_full;

  // front: classify and queue incoming transfers
  rngenc_front #(
    .FreqBits   (FreqBits),
    .QueueDepth (InQueueDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .opcode_i     (opcode_i),
    .cum_freq_i   (cum_freq_i),
    .sym_freq_i   (sym_freq_i),
    .total_freq_i (total_freq_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop)
  );

  // back: coder arithmetic and byte output
  rngenc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .res_o        (res_in),
    .res_push_o   (res_push),
    .res_full_i   (res_full)
  );

  // result queue decouples the back end from the consumer
  rngenc_fifo #(
    .Width ($bits(rngenc_pkg::res_t)),
    .Depth (OutQueueDepth)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign out_byte_o     = res_out.out_byte;
  assign repeat_count_o = res_out.repeat_count;
  assign last_o         = res_out.last;

endmodule
